[rtl/swrl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrl_pkg: shared types and constants of the send rate limiter
// Sizes, register indexes, refusal codes, reset values and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package swrl_pkg;

	localparam int QUEUE_DEPTH = 128;
	localparam int TIME_BITS   = 48;

	localparam int IDX_W   = $clog2(QUEUE_DEPTH);
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W  = IDX_W + 1;
	localparam int SUM_W   = TIME_BITS + 1;
	localparam int MAX_W   = 8;
	localparam int GAP_W   = 16;
	localparam int WIN_W   = 20;
	localparam int LIM_W   = (CNT_W > MAX_W) ? CNT_W : MAX_W;
	localparam int REASON_W = 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam int S_TDATA_W = ((TIME_BITS + 7) / 8) * 8;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 8;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PRIV_MAX     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_MAX   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRIV_GAP     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_GAP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF      = 3'd5;

	// Refusal reasons.
	localparam logic [REASON_W-1:0] REASON_NONE = 2'd0;
	localparam logic [REASON_W-1:0] REASON_FAST = 2'd1;
	localparam logic [REASON_W-1:0] REASON_MANY = 2'd2;

	// Register reset values.
	localparam logic [MAX_W-1:0] RST_PRIV_MAX   = 8'd99;
	localparam logic [MAX_W-1:0] RST_NORMAL_MAX = 8'd19;
	localparam logic [GAP_W-1:0] RST_PRIV_GAP   = 16'd100;
	localparam logic [GAP_W-1:0] RST_NORMAL_GAP = 16'd1100;
	localparam logic [WIN_W-1:0] RST_WINDOW     = 20'd32000;
	localparam logic [WIN_W-1:0] RST_HOLDOFF    = 20'd30000;

	typedef struct packed {
		logic load_in;   // latch a new item and read the newest queue entry
		logic pop;       // drop the oldest entry of the class
		logic push;      // queue the item time, result is accepted
		logic set_fast;  // result is refused as too fast
		logic set_many;  // result is refused as too many
		logic note;      // resolve the notice flag of the refusal
		logic load_out;  // move the result into the output register
	} swrl_cmd_t;

	typedef struct packed {
		logic too_fast;  // newest entry plus gap lies after now
		logic expired;   // oldest entry plus window lies before now
		logic full;      // queue holds the class limit
		logic due;       // notice for the current refusal reason is due
	} swrl_sts_t;

	// Index addition modulo the queue depth; the operand stays below twice the depth.
	function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W:0] v);
		logic [IDX_W:0] r;
		r = (v >= (IDX_W + 1)'(QUEUE_DEPTH)) ? v - (IDX_W + 1)'(QUEUE_DEPTH) : v;
		return r[IDX_W-1:0];
	endfunction

endpackage

[rtl/swrl_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrl_ctrl: sequencing state machine of the send rate limiter
// Walks an item through the gap check and, unless too fast, the expiry sweep and
// limit check, then the notice of a refusal, and loads the output register.
// ----------------------------------------------------------------------------
module swrl_ctrl import swrl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	input  swrl_sts_t sts,
	output swrl_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_GAP  = 3'd1;
	localparam logic [2:0] S_DROP = 3'd2;
	localparam logic [2:0] S_NOTE = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = S_GAP;
				end
			end
			S_GAP: begin
				if (sts.too_fast) begin
					cmd.set_fast = 1'b1;
					state_d      = S_NOTE;
				end else begin
					state_d = S_DROP;
				end
			end
			S_DROP: begin
				if (sts.expired) begin
					cmd.pop = 1'b1;
				end else if (sts.full) begin
					cmd.set_many = 1'b1;
					state_d      = S_NOTE;
				end else begin
					cmd.push = 1'b1;
					state_d  = S_OUT;
				end
			end
			S_NOTE: begin
				cmd.note = 1'b1;
				state_d  = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_to_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_GAP))
		else $error("accepted item did not enter the gap check");

endmodule

[rtl/swrl_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrl_dp: datapath of the send rate limiter
// Holds the configuration, the two timestamp queues in one memory, the queue
// pointers, the notice timers, the working result and the output register.
// ----------------------------------------------------------------------------
module swrl_dp import swrl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [TIME_BITS-1:0]  in_now,
	input  logic                  in_priv,
	input  swrl_cmd_t             cmd,
	output swrl_sts_t             sts,
	output logic                  out_accepted,
	output logic [REASON_W-1:0]   out_reason,
	output logic                  out_notify
);

	// Configuration.
	logic [MAX_W-1:0] priv_max_q, normal_max_q;
	logic [GAP_W-1:0] priv_gap_q, normal_gap_q;
	logic [WIN_W-1:0] window_q, holdoff_q;

	// Item being worked on.
	logic [TIME_BITS-1:0] now_s1;
	logic                 priv_s1;

	// Queue pointers.
	logic [IDX_W-1:0] priv_head_q, normal_head_q;
	logic [CNT_W-1:0] priv_cnt_q, normal_cnt_q;

	// Queue memory, privileged class in the upper half.
	logic [TIME_BITS-1:0] mem_q [2*QUEUE_DEPTH];
	logic [TIME_BITS-1:0] rd_data_q;
	logic [ADDR_W-1:0]    rd_addr, wr_addr;

	// Notice timers.
	logic [TIME_BITS-1:0] speed_time_q, amount_time_q;
	logic                 speed_seen_q, amount_seen_q;

	// Working result.
	logic                res_acc_q, res_notify_q;
	logic [REASON_W-1:0] res_reason_q;

	logic [IDX_W-1:0]     head_sel, head_in, rd_idx, last_idx, wr_idx, head_inc;
	logic [CNT_W-1:0]     cnt_sel, cnt_in;
	logic [GAP_W-1:0]     gap_sel;
	logic [MAX_W-1:0]     max_sel;
	logic [LIM_W-1:0]     lim_sel;
	logic [TIME_BITS-1:0] last_notice;
	logic                 seen_sel, rd_cls;
	logic [SUM_W-1:0]     now_ext;

	function automatic logic [ADDR_W-1:0] mem_addr(input logic cls, input logic [IDX_W-1:0] idx);
		return cls ? ADDR_W'(QUEUE_DEPTH) + ADDR_W'(idx) : ADDR_W'(idx);
	endfunction

	always_comb begin
		head_sel = priv_s1 ? priv_head_q : normal_head_q;
		cnt_sel  = priv_s1 ? priv_cnt_q : normal_cnt_q;
		head_in  = in_priv ? priv_head_q : normal_head_q;
		cnt_in   = in_priv ? priv_cnt_q : normal_cnt_q;
		gap_sel  = priv_s1 ? priv_gap_q : normal_gap_q;
		max_sel  = priv_s1 ? priv_max_q : normal_max_q;
		lim_sel  = (LIM_W'(max_sel) > LIM_W'(QUEUE_DEPTH)) ? LIM_W'(QUEUE_DEPTH)
			: LIM_W'(max_sel);

		// Newest entry of the incoming class: head plus count minus one.
		last_idx = (cnt_in == '0) ? head_in
			: wrap_idx(ADDR_W'(head_in) + ADDR_W'(cnt_in) - ADDR_W'(1));
		head_inc = wrap_idx(ADDR_W'(head_sel) + ADDR_W'(1));
		wr_idx   = wrap_idx(ADDR_W'(head_sel) + ADDR_W'(cnt_sel));

		// During the sweep the read runs one entry ahead of a pop.
		if (cmd.load_in) begin
			rd_idx = last_idx;
			rd_cls = in_priv;
		end else begin
			rd_idx = cmd.pop ? head_inc : head_sel;
			rd_cls = priv_s1;
		end
		rd_addr = mem_addr(rd_cls, rd_idx);
		wr_addr = mem_addr(priv_s1, wr_idx);

		now_ext      = {1'b0, now_s1};
		sts.too_fast = (cnt_sel != '0) &&
			(({1'b0, rd_data_q} + SUM_W'(gap_sel)) > now_ext);
		sts.expired  = (cnt_sel != '0) &&
			(({1'b0, rd_data_q} + SUM_W'(window_q)) < now_ext);
		sts.full     = (LIM_W'(cnt_sel) >= lim_sel);

		last_notice = (res_reason_q == REASON_FAST) ? speed_time_q : amount_time_q;
		seen_sel    = (res_reason_q == REASON_FAST) ? speed_seen_q : amount_seen_q;
		sts.due     = !seen_sel || (({1'b0, last_notice} + SUM_W'(holdoff_q)) < now_ext);
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			priv_max_q   <= RST_PRIV_MAX;
			normal_max_q <= RST_NORMAL_MAX;
			priv_gap_q   <= RST_PRIV_GAP;
			normal_gap_q <= RST_NORMAL_GAP;
			window_q     <= RST_WINDOW;
			holdoff_q    <= RST_HOLDOFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PRIV_MAX:   priv_max_q   <= cfg_data[MAX_W-1:0];
				REG_NORMAL_MAX: normal_max_q <= cfg_data[MAX_W-1:0];
				REG_PRIV_GAP:   priv_gap_q   <= cfg_data[GAP_W-1:0];
				REG_NORMAL_GAP: normal_gap_q <= cfg_data[GAP_W-1:0];
				REG_WINDOW:     window_q     <= cfg_data[WIN_W-1:0];
				REG_HOLDOFF:    holdoff_q    <= cfg_data[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Queue pointers and notice timers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			priv_head_q   <= '0;
			priv_cnt_q    <= '0;
			normal_head_q <= '0;
			normal_cnt_q  <= '0;
			speed_time_q  <= '0;
			amount_time_q <= '0;
			speed_seen_q  <= 1'b0;
			amount_seen_q <= 1'b0;
		end else begin
			if (cmd.pop) begin
				if (priv_s1) begin
					priv_head_q <= head_inc;
					priv_cnt_q  <= priv_cnt_q - CNT_W'(1);
				end else begin
					normal_head_q <= head_inc;
					normal_cnt_q  <= normal_cnt_q - CNT_W'(1);
				end
			end
			if (cmd.push) begin
				if (priv_s1) begin
					priv_cnt_q <= priv_cnt_q + CNT_W'(1);
				end else begin
					normal_cnt_q <= normal_cnt_q + CNT_W'(1);
				end
			end
			if (cmd.note && sts.due) begin
				if (res_reason_q == REASON_FAST) begin
					speed_time_q <= now_s1;
					speed_seen_q <= 1'b1;
				end else begin
					amount_time_q <= now_s1;
					amount_seen_q <= 1'b1;
				end
			end
		end
	end

	// Memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem_q[wr_addr] <= now_s1;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	// Item, working result and output payload.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			now_s1  <= in_now;
			priv_s1 <= in_priv;
		end
		if (cmd.set_fast) begin
			res_acc_q    <= 1'b0;
			res_reason_q <= REASON_FAST;
			res_notify_q <= 1'b0;
		end else if (cmd.set_many) begin
			res_acc_q    <= 1'b0;
			res_reason_q <= REASON_MANY;
			res_notify_q <= 1'b0;
		end else if (cmd.push) begin
			res_acc_q    <= 1'b1;
			res_reason_q <= REASON_NONE;
			res_notify_q <= 1'b0;
		end else if (cmd.note) begin
			res_notify_q <= sts.due;
		end
		if (cmd.load_out) begin
			out_accepted <= res_acc_q;
			out_reason   <= res_reason_q;
			out_notify   <= res_notify_q;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(CNT_W'(QUEUE_DEPTH) >= priv_cnt_q) && (CNT_W'(QUEUE_DEPTH) >= normal_cnt_q))
		else $error("queue count beyond depth");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !sts.full && !sts.expired)
		else $error("push while queue is at its limit");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (cnt_sel != '0))
		else $error("pop from an empty queue");

endmodule

[rtl/sliding_window_send_rate_limiter.sv]
`timescale 1ns / 1ps
// Items are taken one at a time: s_tready is high only in the idle state, and
// the result of an item waits in the output register for m_tready. Expired
// entries are dropped one per cycle through the queue memory port. Reset is
// asynchronous and clears the queues, notice timers and handshakes; registers
// return to defaults.
// ----------------------------------------------------------------------------
// sliding_window_send_rate_limiter: two-class send rate limiter
// Each request carries a millisecond time and a class bit. A request is refused
// as too fast when it follows the newest accepted send of its class by less
// than the class minimum gap. Otherwise expired entries of the class queue are
// dropped, and the request is refused as too many when the queue holds the
// class limit, or else queued and accepted. Each refusal reason has a notice
// holdoff timer shared by both classes.
// ----------------------------------------------------------------------------
module sliding_window_send_rate_limiter import swrl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// Request item stream.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // now_ms
	input  logic [S_TUSER_W-1:0]  s_tuser,   // is_privileged
	// Result item stream.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // accepted, refusal_reason[1:0], notify, zero pad
	// Configuration write channel.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	swrl_cmd_t            cmd;
	swrl_sts_t            sts;
	logic                 out_accepted;
	logic [REASON_W-1:0]  out_reason;
	logic                 out_notify;

	// Register writes are always taken; an index past the list is ignored.
	assign cfg_ready = 1'b1;

	// The controller sequences the item; the datapath holds all storage and
	// compares. The result sits in an output register, so a new item can be
	// accepted while the previous result still waits for the sink.
	swrl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	swrl_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid & cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_now       (s_tdata[TIME_BITS-1:0]),
		.in_priv      (s_tuser[0]),
		.cmd          (cmd),
		.sts          (sts),
		.out_accepted (out_accepted),
		.out_reason   (out_reason),
		.out_notify   (out_notify)
	);

	// Result fields packed from bit 0 upward, the rest of the byte is zero.
	assign m_tdata = {(M_TDATA_W - REASON_W - 2)'(0), out_notify, out_reason, out_accepted};

endmodule

[verif/sliding_window_send_rate_limiter_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_send_rate_limiter_test: self-checking bench of the send limiter
// Drives send requests and register writes, predicts every verdict with a
// behavioral copy of the two class queues and notice timers, and checks each
// verdict on the result stream field by field, under random stalls.
// ----------------------------------------------------------------------------
module sliding_window_send_rate_limiter_test;
	import swrl_pkg::*;

	// Register indexes beyond the register file; writes to them are ignored.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	// Fields of one verdict item on m_tdata.
	typedef struct {
		logic                accepted;
		logic [REASON_W-1:0] reason;
		logic                notify;
	} verdict_t;

	// Flavors of register settings and time steps for the random phases.
	typedef enum {MIX_TYPICAL, MIX_DEEP, MIX_WILD} mix_t;

	// Predicts the verdict of every accepted request and holds the verdicts still due.
	// Class slot 1 is the privileged class, slot 0 the normal class.
	// Notice slot 0 belongs to too-fast refusals, slot 1 to too-many refusals.
	class rate_verdicts;
		logic [MAX_W-1:0]     max_count [2];
		logic [GAP_W-1:0]     min_gap [2];
		logic [WIN_W-1:0]     window_ms;
		logic [WIN_W-1:0]     holdoff_ms;
		logic [TIME_BITS-1:0] sent_log [2][$];
		logic [TIME_BITS-1:0] notice_time [2];
		bit                   notice_seen [2];
		verdict_t             due_verdicts [$];
		int                   failures;

		function new();
			max_count[1]   = RST_PRIV_MAX;
			max_count[0]   = RST_NORMAL_MAX;
			min_gap[1]     = RST_PRIV_GAP;
			min_gap[0]     = RST_NORMAL_GAP;
			window_ms      = RST_WINDOW;
			holdoff_ms     = RST_HOLDOFF;
			notice_time[0] = '0;
			notice_time[1] = '0;
			notice_seen[0] = 1'b0;
			notice_seen[1] = 1'b0;
			failures       = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_PRIV_MAX:   max_count[1] = val[MAX_W-1:0];
				REG_NORMAL_MAX: max_count[0] = val[MAX_W-1:0];
				REG_PRIV_GAP:   min_gap[1] = val[GAP_W-1:0];
				REG_NORMAL_GAP: min_gap[0] = val[GAP_W-1:0];
				REG_WINDOW:     window_ms = val[WIN_W-1:0];
				REG_HOLDOFF:    holdoff_ms = val[WIN_W-1:0];
				default: ;
			endcase
		endfunction

		// The first refusal of a reason always notifies, later ones once the holdoff ran out.
		function logic notice_due(int slot, logic [TIME_BITS-1:0] now);
			if (!notice_seen[slot] || 64'(notice_time[slot]) + 64'(holdoff_ms) < 64'(now)) begin
				notice_time[slot] = now;
				notice_seen[slot] = 1'b1;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_request(logic [TIME_BITS-1:0] now, logic priv);
			int       c;
			int       limit;
			verdict_t v;
			c = priv ? 1 : 0;
			// A limit above the queue depth saturates at the depth.
			limit = (int'(max_count[c]) > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(max_count[c]);
			v.accepted = 1'b0;
			v.reason   = REASON_NONE;
			v.notify   = 1'b0;
			if (sent_log[c].size() > 0 &&
					64'(sent_log[c][$]) + 64'(min_gap[c]) > 64'(now)) begin
				v.reason = REASON_FAST;
				v.notify = notice_due(0, now);
			end else begin
				while (sent_log[c].size() > 0 &&
						64'(sent_log[c][0]) + 64'(window_ms) < 64'(now))
					void'(sent_log[c].pop_front());
				if (sent_log[c].size() >= limit) begin
					v.reason = REASON_MANY;
					v.notify = notice_due(1, now);
				end else begin
					sent_log[c].push_back(now);
					v.accepted = 1'b1;
				end
			end
			due_verdicts.push_back(v);
		endfunction

		function void flag_failure(string what);
			failures++;
			if (failures <= 10)
				$display("%0t ns: %s", $realtime, what);
		endfunction

		function void check_verdict(logic [M_TDATA_W-1:0] word);
			verdict_t want;
			if (due_verdicts.size() == 0) begin
				flag_failure($sformatf("verdict 0x%02h arrived with none outstanding", word));
				return;
			end
			want = due_verdicts.pop_front();
			if (word[0] !== want.accepted || word[2:1] !== want.reason ||
					word[3] !== want.notify)
				flag_failure($sformatf(
					"verdict mismatch: accepted %0d/%0d reason %0d/%0d notify %0d/%0d (exp/got)",
					want.accepted, word[0], want.reason, word[2:1], want.notify, word[3]));
		endfunction

		function int pending();
			return due_verdicts.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic [S_TUSER_W-1:0]  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sliding_window_send_rate_limiter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // now_ms
		.s_tuser   (s_tuser),   // is_privileged
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // accepted, refusal_reason[1:0], notify, zero pad
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	rate_verdicts          book;
	logic [CFG_DATA_W-1:0] cfg_val [6];   // register values of the current phase
	logic [TIME_BITS-1:0]  stamp_ms;      // time of the next request
	bit                    quiet;         // no idling on either side
	bit                    long_hold_req; // asks the receiver for one long stall

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Generous upper bound: the full run needs well under a fifth of this.
	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Receiver: checks every verdict item taken and stalls m_tready in random bursts.
	// A long stall lets the block fill up so that it must hold off the request stream.
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (m_tvalid && m_tready)
					book.check_verdict(m_tdata);
				if (long_hold_req) begin
					stall_left = 600;
					long_hold_req = 1'b0;
				end
				if (stall_left > 0) begin
					stall_left--;
					m_tready <= 1'b0;
				end else if (!quiet && $urandom_range(0, 7) == 0) begin
					// This cycle is the first of the burst.
					stall_left = $urandom_range(0, 13);
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b1;
				end
			end
		end
	end

	// Offers one request and returns at the edge that takes it. Valid stays high, so
	// back-to-back requests need no second assignment in one step.
	task automatic send_request(input logic [TIME_BITS-1:0] now, input logic priv);
		s_tvalid <= 1'b1;
		s_tdata  <= now;
		s_tuser  <= priv;
		do @(posedge clk); while (!s_tready);
		book.note_request(now, priv);
	endtask

	// Random sender gap with valid low before some requests, unless quiet.
	task automatic sender_gap();
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// Lowers valid and waits until every verdict is back and the block has settled.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (book.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		book.write_register(idx, val);
	endtask

	// Writes all six registers from cfg_val, sometimes with a stray write to an
	// unused index, and only then drops the write valid.
	task automatic apply_settings();
		for (int i = 0; i < 6; i++)
			write_register(CFG_IDX_W'(i), cfg_val[i]);
		if ($urandom_range(0, 1) == 0)
			write_register($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
				CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_registers(input int pmax, input int nmax, input int pgap,
			input int ngap, input int win, input int hold);
		cfg_val[REG_PRIV_MAX]   = CFG_DATA_W'(pmax);
		cfg_val[REG_NORMAL_MAX] = CFG_DATA_W'(nmax);
		cfg_val[REG_PRIV_GAP]   = CFG_DATA_W'(pgap);
		cfg_val[REG_NORMAL_GAP] = CFG_DATA_W'(ngap);
		cfg_val[REG_WINDOW]     = CFG_DATA_W'(win);
		cfg_val[REG_HOLDOFF]    = CFG_DATA_W'(hold);
	endtask

	// One random phase: settle, pick settings, then send a run of requests whose
	// times mostly creep forward in small steps so that queues fill, with zero
	// steps, window-sized jumps that expire entries, and rare wild times.
	task automatic run_phase(input mix_t mix, input int count, input int priv_pct,
			input int hold_at, input int pause_at);
		int                   delta_max;
		int                   jump_pct;
		int                   r;
		logic [TIME_BITS-1:0] step;
		drain();
		case (mix)
			MIX_TYPICAL: begin
				set_registers($urandom_range(1, 8), $urandom_range(0, 6), $urandom_range(0, 40),
					$urandom_range(0, 120), $urandom_range(100, 1500), $urandom_range(0, 800));
				delta_max = 60;
				jump_pct  = 5;
			end
			MIX_DEEP: begin
				// Fills a whole privileged queue, then a jump drops it in one go.
				set_registers($urandom_range(0, 1) ? 255 : 128, $urandom_range(1, 128),
					$urandom_range(0, 2), $urandom_range(0, 2), $urandom_range(1500, 3000),
					$urandom_range(0, 5000));
				delta_max = 3;
				jump_pct  = 1;
			end
			default: begin
				for (int i = 0; i < 6; i++)
					cfg_val[i] = CFG_DATA_W'($urandom);
				delta_max = $urandom_range(1, 70000);
				jump_pct  = 10;
			end
		endcase
		apply_settings();
		if ($urandom_range(0, 1) == 0)
			stamp_ms = {16'($urandom_range(0, 65535)), 32'($urandom)};
		for (int i = 0; i < count; i++) begin
			if (i == hold_at)
				long_hold_req = 1'b1;
			if (i == pause_at) begin
				s_tvalid <= 1'b0;
				while (book.pending() != 0) @(posedge clk);
			end else begin
				sender_gap();
			end
			r = $urandom_range(0, 99);
			if (r < jump_pct)
				step = TIME_BITS'($urandom_range(0, int'(cfg_val[REG_WINDOW]) * 3 / 2 + 1));
			else if (r < jump_pct + 10)
				step = '0;
			else
				step = TIME_BITS'($urandom_range(0, delta_max));
			if (mix == MIX_WILD && $urandom_range(0, 24) == 0)
				stamp_ms = {16'($urandom_range(0, 65535)), 32'($urandom)};
			else
				stamp_ms = stamp_ms + step;
			send_request(stamp_ms, $urandom_range(0, 99) < priv_pct);
		end
	endtask

	initial begin
		book          = new();
		quiet         = 1'b0;
		long_hold_req = 1'b0;
		stamp_ms      = '0;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = '0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		// Reset settings: first acceptance, a too-fast refusal that notifies
		// because it is the first, one that does not, exact-gap acceptance,
		// expiry of old entries, and a later too-fast notice after the holdoff.
		send_request(48'd0, 1'b0);
		send_request(48'd0, 1'b0);
		send_request(48'd500, 1'b0);
		send_request(48'd1100, 1'b0);
		send_request(48'd1100, 1'b1);
		send_request(48'd1150, 1'b1);
		send_request(48'd40000, 1'b0);
		send_request(48'd40000, 1'b1);
		send_request(48'd40050, 1'b1);

		// Lowest limits and zero window and holdoff: a zero maximum refuses
		// everything not too fast, and a zero holdoff notifies only once time moves.
		drain();
		set_registers(1, 0, 0, 65535, 0, 0);
		apply_settings();
		send_request(48'd40100, 1'b0);
		send_request(48'd200000, 1'b0);
		send_request(48'd200000, 1'b0);
		send_request(48'd200001, 1'b0);
		send_request(48'd200001, 1'b1);
		send_request(48'd200001, 1'b1);

		// Highest settings, a maximum above the queue depth, the top of the time
		// range where sums must not wrap, and time going backward.
		drain();
		set_registers(255, 128, 65535, 0, 1048575, 1048575);
		apply_settings();
		send_request('1, 1'b1);
		send_request('1, 1'b1);
		send_request('1, 1'b0);
		send_request('1, 1'b0);
		send_request(48'd3, 1'b0);
		send_request(48'd3, 1'b1);
		send_request(48'h5555_5555_5555, 1'b0);
		send_request(48'hAAAA_AAAA_AAAA, 1'b1);

		stamp_ms = 48'd1000;
		run_phase(MIX_TYPICAL, 60, 50, -1, -1);
		// The long receiver stall falls in the middle of a queue fill.
		run_phase(MIX_DEEP, 170, 95, 40, -1);
		run_phase(MIX_WILD, 80, 50, -1, -1);
		// The sender waits for every verdict once in this phase.
		run_phase(MIX_TYPICAL, 80, 50, -1, 40);
		run_phase(MIX_TYPICAL, 80, 10, -1, -1);
		run_phase(MIX_WILD, 60, 50, -1, -1);
		// Last stretch at full rate, with no idling on either side.
		drain();
		quiet = 1'b1;
		run_phase(MIX_TYPICAL, 90, 50, -1, -1);

		s_tvalid <= 1'b0;
		while (book.pending() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (book.failures == 0 && book.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[files.f]
rtl/swrl_pkg.sv
rtl/swrl_ctrl.sv
rtl/swrl_dp.sv
rtl/sliding_window_send_rate_limiter.sv
verif/sliding_window_send_rate_limiter_test.sv
